### rtl/core/drpm_pkg.sv
package drpm_pkg;

  // Motor phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_GAIN     = 4'd1;
  localparam logic [3:0] PH_CONST    = 4'd2;
  localparam logic [3:0] PH_REDUCE   = 4'd3;
  localparam logic [3:0] PH_LOW      = 4'd4;
  localparam logic [3:0] PH_BRAKE    = 4'd5;
  localparam logic [3:0] PH_BRAKING  = 4'd6;
  localparam logic [3:0] PH_STOPPING = 4'd7;
  localparam logic [3:0] PH_STOP     = 4'd8;

  // Event codes
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_ENC_FALL  = 3'd2;
  localparam logic [2:0] OP_TIMER     = 3'd3;
  localparam logic [2:0] OP_STOP_REQ  = 3'd4;
  localparam logic [2:0] OP_EMERGENCY = 3'd5;
  localparam logic [2:0] OP_REDUCE_SN = 3'd6;
  localparam logic [2:0] OP_STOP_SN   = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_START_DUTY   = 3'd0;
  localparam logic [2:0] REG_GAIN_STEP    = 3'd1;
  localparam logic [2:0] REG_HIGH_DUTY    = 3'd2;
  localparam logic [2:0] REG_REDUCE_STEP  = 3'd3;
  localparam logic [2:0] REG_LOW_DUTY     = 3'd4;
  localparam logic [2:0] REG_REDUCE_PULSE = 3'd5;
  localparam logic [2:0] REG_BRAKE_PULSE  = 3'd6;
  localparam logic [2:0] REG_MODE_BITS    = 3'd7;

  // Bit positions within mode_bits
  localparam int MB_PC          = 0;
  localparam int MB_KEEP        = 1;
  localparam int MB_CHECK_STOP  = 2;
  localparam int MB_CHECK_START = 3;
  localparam int MB_DIR         = 4;

  localparam logic [15:0] BRAKE_TICKS = 16'd100;

  typedef struct packed {
    logic [2:0] operation;
    logic       start_sensor_on;
    logic       reduce_sensor_on;
    logic       stop_sensor_on;
  } drpm_in_t;

  typedef struct packed {
    logic [15:0] duty_out;
    logic        duty_written;
    logic        brake_out;
    logic        direction_out;
    logic [3:0]  motor_phase;
    logic        error_out;
    logic        stable_event;
    logic        start_rejected;
  } drpm_out_t;

  typedef struct packed {
    logic [15:0] start_duty;
    logic [15:0] gain_step;
    logic [15:0] high_duty;
    logic [15:0] reduce_step;
    logic [15:0] low_duty;
    logic [31:0] reduce_pulse;
    logic [31:0] brake_pulse;
    logic [4:0]  mode_bits;
  } drpm_cfg_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] duty_now;
    logic [31:0] pulse_count;
    logic [15:0] brake_timer;
    logic        brake_level;
    logic        direction_level;
    logic        error_flag;
  } drpm_state_t;

endpackage

### rtl/core/drpm_step.sv
module drpm_step (
  input  drpm_pkg::drpm_state_t st,
  input  drpm_pkg::drpm_cfg_t   cfg,
  input  drpm_pkg::drpm_in_t    item,
  output drpm_pkg::drpm_state_t st_next,
  output drpm_pkg::drpm_out_t   res
);

  logic        active;
  logic        pc_mode;
  logic [16:0] gain_sum;
  logic [16:0] reduce_limit;
  logic [15:0] tick_duty;
  logic [3:0]  tick_phase;
  logic        tick_stable;
  logic        tick_brake;
  logic [15:0] tick_timer;
  logic        tick_error;
  logic [31:0] count_inc;
  logic        written;
  logic        stable;
  logic        rejected;

  assign active  = (st.phase != drpm_pkg::PH_IDLE) && (st.phase < drpm_pkg::PH_STOP);
  assign pc_mode = cfg.mode_bits[drpm_pkg::MB_PC];

  assign gain_sum     = {1'b0, st.duty_now} + {1'b0, cfg.gain_step};
  assign reduce_limit = {1'b0, cfg.low_duty} + {1'b0, cfg.reduce_step};
  assign count_inc    = (&st.pulse_count) ? st.pulse_count : st.pulse_count + 32'd1;

  // Control tick: ramp, pulse-count checks, then the brake and stop sequence.
  always_comb begin
    tick_duty   = st.duty_now;
    tick_phase  = st.phase;
    tick_stable = 1'b0;
    tick_brake  = st.brake_level;
    tick_timer  = st.brake_timer;
    tick_error  = st.error_flag;

    if (st.phase == drpm_pkg::PH_GAIN) begin
      if (st.duty_now >= cfg.high_duty) begin
        tick_duty   = cfg.high_duty;
        tick_phase  = drpm_pkg::PH_CONST;
        tick_stable = 1'b1;
      end else begin
        tick_duty = gain_sum[16] ? 16'hFFFF : gain_sum[15:0];
      end
    end else if (st.phase == drpm_pkg::PH_REDUCE) begin
      if (cfg.reduce_step == '0) begin
        if (pc_mode) begin
          tick_duty  = cfg.low_duty;
          tick_phase = drpm_pkg::PH_LOW;
        end else begin
          tick_duty  = '0;
          tick_phase = drpm_pkg::PH_BRAKE;
        end
      end else if ({1'b0, st.duty_now} > reduce_limit) begin
        tick_duty = st.duty_now - cfg.reduce_step;
      end else if (st.duty_now != '0) begin
        tick_duty  = cfg.low_duty;
        tick_phase = drpm_pkg::PH_LOW;
      end
    end

    if (pc_mode) begin
      if (st.pulse_count >= cfg.brake_pulse) begin
        tick_duty = '0;
        if (tick_phase < drpm_pkg::PH_BRAKE) begin
          tick_phase = drpm_pkg::PH_BRAKE;
        end
      end else if (st.pulse_count >= cfg.reduce_pulse) begin
        if (tick_phase < drpm_pkg::PH_REDUCE) begin
          tick_phase = drpm_pkg::PH_REDUCE;
        end
      end
    end

    if (tick_phase == drpm_pkg::PH_BRAKE) begin
      tick_brake = 1'b1;
      if (drpm_pkg::BRAKE_TICKS != '0) begin
        tick_timer = drpm_pkg::BRAKE_TICKS;
        tick_phase = drpm_pkg::PH_BRAKING;
      end else begin
        tick_phase = drpm_pkg::PH_STOPPING;
      end
    end

    if (tick_phase == drpm_pkg::PH_STOPPING) begin
      if (!cfg.mode_bits[drpm_pkg::MB_KEEP]) begin
        tick_brake = 1'b0;
      end
      tick_phase = drpm_pkg::PH_STOP;
      if (cfg.mode_bits[drpm_pkg::MB_CHECK_STOP] && !item.stop_sensor_on) begin
        tick_error = 1'b1;
      end
    end
  end

  always_comb begin
    st_next  = st;
    written  = 1'b0;
    stable   = 1'b0;
    rejected = 1'b0;

    unique case (item.operation)
      drpm_pkg::OP_START: begin
        if (cfg.mode_bits[drpm_pkg::MB_CHECK_START] && (!item.start_sensor_on
            || item.reduce_sensor_on || item.stop_sensor_on)) begin
          rejected = 1'b1;
        end else begin
          st_next.direction_level = cfg.mode_bits[drpm_pkg::MB_DIR];
          if (cfg.gain_step != '0) begin
            st_next.duty_now = cfg.start_duty;
            st_next.phase    = drpm_pkg::PH_GAIN;
          end else begin
            st_next.duty_now = cfg.high_duty;
            st_next.phase    = drpm_pkg::PH_CONST;
          end
          st_next.pulse_count = '0;
          st_next.error_flag  = 1'b0;
          st_next.brake_timer = '0;
          written             = 1'b1;
        end
      end
      drpm_pkg::OP_TICK: begin
        if (active) begin
          st_next.duty_now    = tick_duty;
          st_next.phase       = tick_phase;
          st_next.brake_level = tick_brake;
          st_next.brake_timer = tick_timer;
          st_next.error_flag  = tick_error;
          written             = (tick_duty != st.duty_now);
          stable              = tick_stable;
        end
      end
      drpm_pkg::OP_ENC_FALL: begin
        st_next.pulse_count = count_inc;
        if (pc_mode && active && (st.duty_now != '0) && (count_inc >= cfg.brake_pulse)) begin
          st_next.duty_now = '0;
          written          = 1'b1;
        end
      end
      drpm_pkg::OP_TIMER: begin
        if (st.brake_timer != '0) begin
          st_next.brake_timer = st.brake_timer - 16'd1;
          if ((st.brake_timer == 16'd1) && (st.phase == drpm_pkg::PH_BRAKING)) begin
            st_next.phase = drpm_pkg::PH_STOPPING;
          end
        end
      end
      drpm_pkg::OP_STOP_REQ: begin
        if (active) begin
          st_next.phase = drpm_pkg::PH_REDUCE;
        end
      end
      drpm_pkg::OP_EMERGENCY: begin
        st_next.duty_now = '0;
        written          = 1'b1;
        if (active) begin
          st_next.phase = drpm_pkg::PH_REDUCE;
        end
      end
      drpm_pkg::OP_REDUCE_SN: begin
        if ((st.phase != drpm_pkg::PH_IDLE) && (st.phase < drpm_pkg::PH_REDUCE)
            && item.reduce_sensor_on) begin
          st_next.phase = drpm_pkg::PH_REDUCE;
        end
      end
      drpm_pkg::OP_STOP_SN: begin
        if ((st.phase != drpm_pkg::PH_IDLE) && (st.phase < drpm_pkg::PH_BRAKE)
            && item.stop_sensor_on) begin
          st_next.duty_now = '0;
          st_next.phase    = drpm_pkg::PH_BRAKE;
          written          = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.duty_out       = st_next.duty_now;
    res.duty_written   = written;
    res.brake_out      = st_next.brake_level;
    res.direction_out  = st_next.direction_level;
    res.motor_phase    = st_next.phase;
    res.error_out      = st_next.error_flag;
    res.stable_event   = stable;
    res.start_rejected = rejected;
  end

endmodule

### rtl/core/duty_ramp_position_motor_top.sv
// Event-driven positioning controller for a PWM motor. Every accepted event yields exactly
// one result carrying the duty, brake, direction, phase and error flag after that event.
// One event is taken per clock cycle while in_ready is high; an event is held in the input
// register, is evaluated there against the motor state and leaves through the result
// register when the output is not stalled. The whole evaluation is a single pass through
// the 17-bit ramp sums, the 32-bit pulse increment and the 32-bit pulse compares.
// in_ready follows out_ready combinationally once both registers hold data. Configuration
// writes are always accepted and should only be issued while no event is in flight.
module duty_ramp_position_motor_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  drpm_pkg::drpm_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output drpm_pkg::drpm_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  drpm_pkg::drpm_cfg_t   cfg;
  drpm_pkg::drpm_state_t state;
  drpm_pkg::drpm_state_t state_next;
  drpm_pkg::drpm_in_t    stage_data;
  drpm_pkg::drpm_out_t   res;
  logic                  stage_valid;
  logic                  advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        drpm_pkg::REG_START_DUTY:   cfg.start_duty   <= cfg_data[15:0];
        drpm_pkg::REG_GAIN_STEP:    cfg.gain_step    <= cfg_data[15:0];
        drpm_pkg::REG_HIGH_DUTY:    cfg.high_duty    <= cfg_data[15:0];
        drpm_pkg::REG_REDUCE_STEP:  cfg.reduce_step  <= cfg_data[15:0];
        drpm_pkg::REG_LOW_DUTY:     cfg.low_duty     <= cfg_data[15:0];
        drpm_pkg::REG_REDUCE_PULSE: cfg.reduce_pulse <= cfg_data;
        drpm_pkg::REG_BRAKE_PULSE:  cfg.brake_pulse  <= cfg_data;
        drpm_pkg::REG_MODE_BITS:    cfg.mode_bits    <= cfg_data[4:0];
      endcase
    end
  end

  // Input register: holds one event until the result register can take its outcome.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_data <= '0;
    end else if (in_ready) begin
      stage_data <= in_data;
    end
  end

  drpm_step u_step (
    .st      (state),
    .cfg     (cfg),
    .item    (stage_data),
    .st_next (state_next),
    .res     (res)
  );

  // The motor state moves on only when the event leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (stage_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_valid && advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance) begin
      out_data <= res;
    end
  end

  a_result_from_stage : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid))
    else $error("result appeared without an event in the input register");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid && out_valid && !out_ready)
    else $error("input stalled while the pipeline could move");

  a_reject_no_write : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.start_rejected |-> !out_data.duty_written)
    else $error("rejected start reported a duty write");

  a_stable_phase : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stable_event |->
      out_data.motor_phase == drpm_pkg::PH_CONST ||
      out_data.motor_phase == drpm_pkg::PH_REDUCE ||
      out_data.duty_out == '0)
    else $error("stable event reported outside the running phases");

endmodule

### dv/tb_duty_ramp_position_motor_top.sv
module tb_duty_ramp_position_motor_top;

  localparam int WATCHDOG_LIMIT = 1000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  drpm_pkg::drpm_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  drpm_pkg::drpm_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_data;

  // Local copy of the motor controller: registers and state.
  drpm_pkg::drpm_cfg_t regs = '0;
  logic [3:0]  ph = drpm_pkg::PH_IDLE;
  logic [15:0] duty = '0;
  logic [31:0] pulses = '0;
  logic [15:0] brake_ticks_left = '0;
  logic        brake_on = 1'b0;
  logic        dir_on = 1'b0;
  logic        fault = 1'b0;

  drpm_pkg::drpm_out_t predicted_status[$];
  int          failures = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  duty_ramp_position_motor_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly no pause or a short one, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic drpm_pkg::drpm_in_t make_event(logic [2:0] op, logic s, logic r,
                                                    logic p);
    drpm_pkg::drpm_in_t ev;
    ev.operation = op;
    ev.start_sensor_on = s;
    ev.reduce_sensor_on = r;
    ev.stop_sensor_on = p;
    return ev;
  endfunction

  // Works out the status after one event and moves the local state on.
  task automatic advance_motor(input drpm_pkg::drpm_in_t ev, output drpm_pkg::drpm_out_t res);
    int unsigned t;
    bit written;
    bit stable;
    bit rejected;
    bit active;
    written = 1'b0;
    stable = 1'b0;
    rejected = 1'b0;
    active = (ph != drpm_pkg::PH_IDLE) && (ph < drpm_pkg::PH_STOP);
    case (ev.operation)
      drpm_pkg::OP_START: begin
        if (regs.mode_bits[drpm_pkg::MB_CHECK_START] &&
            (!ev.start_sensor_on || ev.reduce_sensor_on || ev.stop_sensor_on)) begin
          rejected = 1'b1;
        end else begin
          dir_on = regs.mode_bits[drpm_pkg::MB_DIR];
          if (regs.gain_step != 0) begin
            duty = regs.start_duty;
            ph = drpm_pkg::PH_GAIN;
          end else begin
            duty = regs.high_duty;
            ph = drpm_pkg::PH_CONST;
          end
          pulses = '0;
          fault = 1'b0;
          brake_ticks_left = '0;
          written = 1'b1;
        end
      end
      drpm_pkg::OP_TICK: begin
        if (active) begin
          t = 32'(duty);
          if (ph == drpm_pkg::PH_GAIN) begin
            if (t >= 32'(regs.high_duty)) begin
              t = 32'(regs.high_duty);
              ph = drpm_pkg::PH_CONST;
              stable = 1'b1;
            end else begin
              t = t + 32'(regs.gain_step);
              if (t > 32'h0000_FFFF) t = 32'h0000_FFFF;
            end
          end else if (ph == drpm_pkg::PH_REDUCE) begin
            if (regs.reduce_step == 0) begin
              if (regs.mode_bits[drpm_pkg::MB_PC]) begin
                t = 32'(regs.low_duty);
                ph = drpm_pkg::PH_LOW;
              end else begin
                t = 0;
                ph = drpm_pkg::PH_BRAKE;
              end
            end else if (t > 32'(regs.low_duty) + 32'(regs.reduce_step)) begin
              t = t - 32'(regs.reduce_step);
            end else if (t != 0) begin
              t = 32'(regs.low_duty);
              ph = drpm_pkg::PH_LOW;
            end
          end
          if (regs.mode_bits[drpm_pkg::MB_PC]) begin
            if (pulses >= regs.brake_pulse) begin
              t = 0;
              if (ph < drpm_pkg::PH_BRAKE) ph = drpm_pkg::PH_BRAKE;
            end else if (pulses >= regs.reduce_pulse && ph < drpm_pkg::PH_REDUCE) begin
              ph = drpm_pkg::PH_REDUCE;
            end
          end
          if (t[15:0] != duty) begin
            duty = t[15:0];
            written = 1'b1;
          end
          if (ph == drpm_pkg::PH_BRAKE) begin
            brake_on = 1'b1;
            if (drpm_pkg::BRAKE_TICKS != 0) begin
              brake_ticks_left = drpm_pkg::BRAKE_TICKS;
              ph = drpm_pkg::PH_BRAKING;
            end else begin
              ph = drpm_pkg::PH_STOPPING;
            end
          end
          if (ph == drpm_pkg::PH_STOPPING) begin
            if (!regs.mode_bits[drpm_pkg::MB_KEEP]) brake_on = 1'b0;
            ph = drpm_pkg::PH_STOP;
            if (regs.mode_bits[drpm_pkg::MB_CHECK_STOP] && !ev.stop_sensor_on) fault = 1'b1;
          end
        end
      end
      drpm_pkg::OP_ENC_FALL: begin
        if (pulses != 32'hFFFF_FFFF) pulses = pulses + 32'd1;
        if (regs.mode_bits[drpm_pkg::MB_PC] && active && duty != 0 &&
            pulses >= regs.brake_pulse) begin
          duty = '0;
          written = 1'b1;
        end
      end
      drpm_pkg::OP_TIMER: begin
        if (brake_ticks_left != 0) begin
          brake_ticks_left = brake_ticks_left - 16'd1;
          if (brake_ticks_left == 0 && ph == drpm_pkg::PH_BRAKING) ph = drpm_pkg::PH_STOPPING;
        end
      end
      drpm_pkg::OP_STOP_REQ: begin
        if (active) ph = drpm_pkg::PH_REDUCE;
      end
      drpm_pkg::OP_EMERGENCY: begin
        duty = '0;
        written = 1'b1;
        if (active) ph = drpm_pkg::PH_REDUCE;
      end
      drpm_pkg::OP_REDUCE_SN: begin
        if (ph != drpm_pkg::PH_IDLE && ph < drpm_pkg::PH_REDUCE && ev.reduce_sensor_on) begin
          ph = drpm_pkg::PH_REDUCE;
        end
      end
      drpm_pkg::OP_STOP_SN: begin
        if (ph != drpm_pkg::PH_IDLE && ph < drpm_pkg::PH_BRAKE && ev.stop_sensor_on) begin
          duty = '0;
          written = 1'b1;
          ph = drpm_pkg::PH_BRAKE;
        end
      end
    endcase
    res.duty_out = duty;
    res.duty_written = written;
    res.brake_out = brake_on;
    res.direction_out = dir_on;
    res.motor_phase = ph;
    res.error_out = fault;
    res.stable_event = stable;
    res.start_rejected = rejected;
  endtask

  task automatic send_event(input drpm_pkg::drpm_in_t ev);
    int unsigned gap;
    drpm_pkg::drpm_out_t want;
    gap = gaps_on ? pause_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    advance_motor(ev, want);
    predicted_status.push_back(want);
  endtask

  // Lets every outstanding result come back, then lets the pipeline drain.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      drpm_pkg::REG_START_DUTY:   regs.start_duty = value[15:0];
      drpm_pkg::REG_GAIN_STEP:    regs.gain_step = value[15:0];
      drpm_pkg::REG_HIGH_DUTY:    regs.high_duty = value[15:0];
      drpm_pkg::REG_REDUCE_STEP:  regs.reduce_step = value[15:0];
      drpm_pkg::REG_LOW_DUTY:     regs.low_duty = value[15:0];
      drpm_pkg::REG_REDUCE_PULSE: regs.reduce_pulse = value;
      drpm_pkg::REG_BRAKE_PULSE:  regs.brake_pulse = value;
      drpm_pkg::REG_MODE_BITS:    regs.mode_bits = value[4:0];
    endcase
  endtask

  // Unused upper bits carry random junk, which the block has to ignore.
  task automatic apply_settings(input drpm_pkg::drpm_cfg_t s);
    settle_block();
    write_register(drpm_pkg::REG_START_DUTY, {16'($urandom), s.start_duty});
    write_register(drpm_pkg::REG_GAIN_STEP, {16'($urandom), s.gain_step});
    write_register(drpm_pkg::REG_HIGH_DUTY, {16'($urandom), s.high_duty});
    write_register(drpm_pkg::REG_REDUCE_STEP, {16'($urandom), s.reduce_step});
    write_register(drpm_pkg::REG_LOW_DUTY, {16'($urandom), s.low_duty});
    write_register(drpm_pkg::REG_REDUCE_PULSE, s.reduce_pulse);
    write_register(drpm_pkg::REG_BRAKE_PULSE, s.brake_pulse);
    write_register(drpm_pkg::REG_MODE_BITS, {27'($urandom), s.mode_bits});
    cfg_valid <= 1'b0;
  endtask

  function automatic drpm_pkg::drpm_cfg_t random_settings();
    drpm_pkg::drpm_cfg_t s;
    s.high_duty = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
    s.start_duty = 16'($urandom_range(0, s.high_duty));
    case ($urandom_range(0, 5))
      0:       s.gain_step = '0;
      1:       s.gain_step = 16'($urandom);
      default: s.gain_step = 16'($urandom_range(1, 4000));
    endcase
    case ($urandom_range(0, 4))
      0:       s.reduce_step = '0;
      1:       s.reduce_step = 16'($urandom);
      default: s.reduce_step = 16'($urandom_range(1, 3000));
    endcase
    s.low_duty = 16'($urandom_range(0, s.high_duty / 2));
    if ($urandom_range(0, 9) == 0) begin
      s.reduce_pulse = $urandom;
      s.brake_pulse = $urandom;
    end else begin
      s.reduce_pulse = $urandom_range(0, 20);
      s.brake_pulse = s.reduce_pulse + $urandom_range(0, 25);
    end
    s.mode_bits = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 4) != 0) s.mode_bits[drpm_pkg::MB_PC] = 1'b1;
    return s;
  endfunction

  // Event choice follows the motor phase so that runs reach braking and stop.
  function automatic drpm_pkg::drpm_in_t pick_event();
    drpm_pkg::drpm_in_t ev;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    ev = make_event(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom), 1'($urandom));
    if (ph == drpm_pkg::PH_IDLE || ph == drpm_pkg::PH_STOP) begin
      if (roll < 55) ev.operation = drpm_pkg::OP_START;
    end else if (ph == drpm_pkg::PH_BRAKING) begin
      if (roll < 96) ev.operation = drpm_pkg::OP_TIMER;
    end else if (roll < 42) begin
      ev.operation = drpm_pkg::OP_TICK;
    end else if (roll < 80) begin
      ev.operation = drpm_pkg::OP_ENC_FALL;
    end
    if (ev.operation == drpm_pkg::OP_START && $urandom_range(0, 3) != 0) begin
      ev.start_sensor_on = 1'b1;
      ev.reduce_sensor_on = 1'b0;
      ev.stop_sensor_on = 1'b0;
    end
    return ev;
  endfunction

  task automatic test_gain_ramp_and_pulse_count();
    apply_settings('{start_duty: 16'hFFF0, gain_step: 16'hFFFF, high_duty: 16'hFFFF,
                     reduce_step: 16'h0100, low_duty: 16'h0040, reduce_pulse: 32'd2,
                     brake_pulse: 32'd4,
                     mode_bits: 5'((1 << drpm_pkg::MB_PC) | (1 << drpm_pkg::MB_CHECK_STOP) |
                                   (1 << drpm_pkg::MB_DIR))});
    // Idle: emergency still zeroes the duty, ticks and timer expiries do nothing.
    send_event(make_event(drpm_pkg::OP_EMERGENCY, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TIMER, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_START, 1'b0, 1'b1, 1'b1));
    // The ramp sum saturates, and the next tick reports the stable event.
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_ENC_FALL, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_ENC_FALL, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_EMERGENCY, 1'b0, 1'b0, 1'b0));
    // Reducing with the duty already at zero stays in reduce.
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_ENC_FALL, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_ENC_FALL, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TIMER, 1'b0, 1'b0, 1'b0));
    // A restart during braking keeps the brake level.
    send_event(make_event(drpm_pkg::OP_START, 1'b1, 1'b1, 1'b1));
    send_event(make_event(drpm_pkg::OP_STOP_SN, 1'b1, 1'b1, 1'b1));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_start_check_and_jumps();
    apply_settings('{start_duty: 16'h0000, gain_step: 16'h0000, high_duty: 16'h1234,
                     reduce_step: 16'h0000, low_duty: 16'h0020, reduce_pulse: 32'd0,
                     brake_pulse: 32'hFFFF_FFFF,
                     mode_bits: 5'((1 << drpm_pkg::MB_CHECK_START) |
                                   (1 << drpm_pkg::MB_KEEP))});
    send_event(make_event(drpm_pkg::OP_START, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_START, 1'b1, 1'b1, 1'b0));
    send_event(make_event(drpm_pkg::OP_START, 1'b1, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_REDUCE_SN, 1'b0, 1'b1, 1'b0));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_STOP_REQ, 1'b0, 1'b0, 1'b0));
    send_event(make_event(drpm_pkg::OP_TICK, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_random_runs();
    drpm_pkg::drpm_cfg_t s;
    for (int round = 0; round < 5; round++) begin
      s = random_settings();
      if (round == 1) begin
        s = '1;
      end else if (round == 3) begin
        s = '0;
      end
      apply_settings(s);
      // One round runs with both sides streaming back to back.
      gaps_on = (round != 2);
      stalls_on = (round != 2);
      repeat (90) send_event(pick_event());
    end
  endtask

  task automatic note_failure(input string what, input drpm_pkg::drpm_out_t want,
                              input drpm_pkg::drpm_out_t got);
    failures++;
    if (failures <= 10) begin
      $display("%s: expected duty=%h wr=%b brk=%b dir=%b ph=%0d err=%b stb=%b rej=%b",
               what, want.duty_out, want.duty_written, want.brake_out, want.direction_out,
               want.motor_phase, want.error_out, want.stable_event, want.start_rejected);
      $display("  actual duty=%h wr=%b brk=%b dir=%b ph=%0d err=%b stb=%b rej=%b",
               got.duty_out, got.duty_written, got.brake_out, got.direction_out,
               got.motor_phase, got.error_out, got.stable_event, got.start_rejected);
    end
  endtask

  always @(posedge clk) begin
    drpm_pkg::drpm_out_t want;
    string bad;
    if (!rst && out_valid && out_ready) begin
      if (predicted_status.size() == 0) begin
        note_failure("result with nothing expected", '0, out_data);
      end else begin
        want = predicted_status.pop_front();
        bad = "";
        if (out_data.duty_out !== want.duty_out) bad = {bad, " duty_out"};
        if (out_data.duty_written !== want.duty_written) bad = {bad, " duty_written"};
        if (out_data.brake_out !== want.brake_out) bad = {bad, " brake_out"};
        if (out_data.direction_out !== want.direction_out) bad = {bad, " direction_out"};
        if (out_data.motor_phase !== want.motor_phase) bad = {bad, " motor_phase"};
        if (out_data.error_out !== want.error_out) bad = {bad, " error_out"};
        if (out_data.stable_event !== want.stable_event) bad = {bad, " stable_event"};
        if (out_data.start_rejected !== want.start_rejected) bad = {bad, " start_rejected"};
        if (bad != "") note_failure({"mismatch in", bad}, want, out_data);
      end
    end
  end

  // Counts cycles without any transfer on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("duty_ramp_position_motor_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = stalls_on ? pause_len() : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = drpm_pkg::REG_START_DUTY;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_gain_ramp_and_pulse_count();
    test_start_check_and_jumps();
    test_random_runs();
    settle_block();
    repeat (4) @(posedge clk);
    if (predicted_status.size() != 0) failures++;
    if (failures == 0) begin
      $display("duty_ramp_position_motor_top verification clean");
    end else begin
      $display("duty_ramp_position_motor_top verification failed");
    end
    $finish;
  end

endmodule

### duty_ramp_position_motor_top.f
rtl/core/drpm_pkg.sv
rtl/core/drpm_step.sv
rtl/core/duty_ramp_position_motor_top.sv
dv/tb_duty_ramp_position_motor_top.sv
